FILE: src/ldlk_pkg.sv
// Package for the Laplace double-layer pair kernel.
// Types, widths and constants shared by every module of the block.
// No dependencies.
`timescale 1ns / 1ps

package ldlk_pkg;

   // Field widths
   localparam int BARY_W  = 16;
   localparam int COORD_W = 16;
   localparam int VEC_W   = 48;
   localparam int KV_W    = 32;

   // Front datapath widths
   localparam int WGT_W  = 18;   // w = 1 - u - v, signed Q0.16 with headroom
   localparam int PROD_W = 34;   // weight times coordinate
   localparam int PNT_W  = 36;   // mapped point, Q.28
   localparam int DIFF_W = 37;   // point difference, Q.28
   localparam int RND_SH = 12;   // Q.28 to Q.16
   localparam int D_W    = 23;   // rounded difference, Q.16
   localparam int SQ_W   = 44;   // one squared component
   localparam int ND_W   = 39;   // one normal times difference product
   localparam int S_W    = 45;   // squared distance, Q.32
   localparam int NDU_W  = 40;   // n.d, signed Q.30

   // Back datapath widths
   localparam int MAG_W  = 39;   // |n.d|
   localparam int Q_W    = 31;   // floor(sqrt(s * 2^16))
   localparam int X_W    = 2 * Q_W;
   localparam int LO_W   = 32;   // low part of a split multiplier operand
   localparam int NUM_W  = 78;   // |n.d| * K * 2^10
   localparam int DEN_W  = 76;   // s * q
   localparam int QUO_W  = 33;   // quotient bits kept before the range check
   localparam int NUM_SH = 10;

   // round(2^32 / (4*pi))
   localparam int INV4PI_W = 29;
   localparam logic [INV4PI_W-1:0] INV_4PI_Q32 = 29'd341782638;

   // Register file
   localparam int CSR_ADDR_W = 6;
   localparam int CSR_DATA_W = 64;
   localparam logic [2:0] REG_ADJOINT_MODE    = 3'd0;
   localparam logic [2:0] REG_SOURCE_VERTEX_A = 3'd1;
   localparam logic [2:0] REG_SOURCE_VERTEX_B = 3'd2;
   localparam logic [2:0] REG_SOURCE_VERTEX_C = 3'd3;
   localparam logic [2:0] REG_TARGET_VERTEX_A = 3'd4;
   localparam logic [2:0] REG_TARGET_VERTEX_B = 3'd5;
   localparam logic [2:0] REG_TARGET_VERTEX_C = 3'd6;
   localparam logic [2:0] REG_SURFACE_NORMAL  = 3'd7;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int PTR_W       = 2;
   localparam int CNT_W       = 3;

   typedef struct packed {
      logic [BARY_W-1:0] source_bary_u;
      logic [BARY_W-1:0] source_bary_v;
      logic [BARY_W-1:0] target_bary_u;
      logic [BARY_W-1:0] target_bary_v;
   } req_payload_type;

   typedef struct packed {
      logic signed [KV_W-1:0] kernel_value;
      logic                   saturated;
      logic                   zero_distance;
   } rsp_payload_type;

   typedef struct packed {
      logic             adjoint_mode;
      logic [VEC_W-1:0] source_vertex_a;
      logic [VEC_W-1:0] source_vertex_b;
      logic [VEC_W-1:0] source_vertex_c;
      logic [VEC_W-1:0] target_vertex_a;
      logic [VEC_W-1:0] target_vertex_b;
      logic [VEC_W-1:0] target_vertex_c;
      logic [VEC_W-1:0] surface_normal;
   } cfg_type;

   // Geometry of one item as it leaves the front
   typedef struct packed {
      logic [S_W-1:0]          s;
      logic signed [NDU_W-1:0] ndu;
   } geom_type;

   // One signed 16-bit lane of a packed x,y,z vector
   function automatic logic signed [COORD_W-1:0] coord_lane(
      input logic [VEC_W-1:0] vec,
      input logic [1:0]       axis
   );
      logic [VEC_W-1:0] sh;
      sh = vec >> (COORD_W * axis);
      return sh[COORD_W-1:0];
   endfunction

endpackage

FILE: src/laplace_double_layer_pair_kernel.sv
// Top level of the Laplace double-layer pair kernel.
// Depends on ldlk_pkg, ldlk_csr, ldlk_front, ldlk_fifo and ldlk_back.
//
//   channel   ports                              moves
//   req       req_valid / req_stall / req_payload  barycentrics of a point pair
//   rsp       rsp_valid / rsp_stall / rsp_payload  kernel value and flags
//   csr       psel penable pwrite paddr pwdata     eight registers at 8*i
//             prdata pready
//
// One item enters per cycle while req_stall is low; a result passes six front
// stages, one queue slot, an entry stage, 31 square-root stages, two
// multiply stages, a range check, 33 division stages and the output register.
// Reset (synchronous) empties the pipeline and clears the queue and the CSRs;
// datapath registers are not reset. A stall on rsp freezes the back; the front
// keeps running until the four-entry queue fills, then raises req_stall.
`timescale 1ns / 1ps

module laplace_double_layer_pair_kernel (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  ldlk_pkg::req_payload_type       req_payload,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output ldlk_pkg::rsp_payload_type       rsp_payload,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [ldlk_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [ldlk_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [ldlk_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready
);
   import ldlk_pkg::*;

   cfg_type  cfg;
   logic     queue_full;
   logic     push;
   geom_type push_data;
   logic     pop;
   logic     pop_valid;
   geom_type pop_data;

   ldlk_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   ldlk_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .cfg         (cfg),
      .queue_full  (queue_full),
      .push        (push),
      .push_data   (push_data)
   );

   ldlk_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (pop),
      .pop_valid (pop_valid),
      .pop_data  (pop_data)
   );

   ldlk_back u_back (
      .clock       (clock),
      .reset       (reset),
      .pop_valid   (pop_valid),
      .pop_data    (pop_data),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

FILE: src/ldlk_csr.sv
// Configuration registers of the pair kernel with their APB-style port.
// Depends on ldlk_pkg.
`timescale 1ns / 1ps

module ldlk_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [ldlk_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [ldlk_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [ldlk_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready,
   output ldlk_pkg::cfg_type               cfg
);
   import ldlk_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic       wr_en;
   logic [2:0] reg_idx;

   assign pready  = 1'b1;
   assign reg_idx = paddr[CSR_ADDR_W-1:3];
   assign wr_en   = psel && penable && pwrite;
   assign cfg     = cfg_ff;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_ADJOINT_MODE:    cfg_in.adjoint_mode    = pwdata[0];
            REG_SOURCE_VERTEX_A: cfg_in.source_vertex_a = pwdata[VEC_W-1:0];
            REG_SOURCE_VERTEX_B: cfg_in.source_vertex_b = pwdata[VEC_W-1:0];
            REG_SOURCE_VERTEX_C: cfg_in.source_vertex_c = pwdata[VEC_W-1:0];
            REG_TARGET_VERTEX_A: cfg_in.target_vertex_a = pwdata[VEC_W-1:0];
            REG_TARGET_VERTEX_B: cfg_in.target_vertex_b = pwdata[VEC_W-1:0];
            REG_TARGET_VERTEX_C: cfg_in.target_vertex_c = pwdata[VEC_W-1:0];
            REG_SURFACE_NORMAL:  cfg_in.surface_normal  = pwdata[VEC_W-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read mux
   always_comb begin
      case (reg_idx)
         REG_ADJOINT_MODE:    prdata = CSR_DATA_W'(cfg_ff.adjoint_mode);
         REG_SOURCE_VERTEX_A: prdata = CSR_DATA_W'(cfg_ff.source_vertex_a);
         REG_SOURCE_VERTEX_B: prdata = CSR_DATA_W'(cfg_ff.source_vertex_b);
         REG_SOURCE_VERTEX_C: prdata = CSR_DATA_W'(cfg_ff.source_vertex_c);
         REG_TARGET_VERTEX_A: prdata = CSR_DATA_W'(cfg_ff.target_vertex_a);
         REG_TARGET_VERTEX_B: prdata = CSR_DATA_W'(cfg_ff.target_vertex_b);
         REG_TARGET_VERTEX_C: prdata = CSR_DATA_W'(cfg_ff.target_vertex_c);
         REG_SURFACE_NORMAL:  prdata = CSR_DATA_W'(cfg_ff.surface_normal);
         default:             prdata = '0;
      endcase
   end

endmodule

FILE: src/ldlk_front.sv
// Front of the pair kernel: takes items, maps both points, forms the
// rounded difference, |d|^2 and n.d, and pushes them into the queue.
// Depends on ldlk_pkg.
`timescale 1ns / 1ps

module ldlk_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  ldlk_pkg::req_payload_type req_payload,
   input  ldlk_pkg::cfg_type         cfg,
   input  logic                      queue_full,
   output logic                      push,
   output ldlk_pkg::geom_type        push_data
);
   import ldlk_pkg::*;

   localparam int STG_N = 6;

   logic              en;
   logic [STG_N-1:0]  vld_ff, vld_in;

   req_payload_type   bary_ff, bary_in;
   logic signed [WGT_W-1:0]   wgt [2][3];
   logic [VEC_W-1:0]          vert [2][3];
   logic signed [PROD_W-1:0]  prod_ff [2][3][3];
   logic signed [PROD_W-1:0]  prod_in [2][3][3];
   logic signed [PNT_W-1:0]   pnt_ff [2][3];
   logic signed [PNT_W-1:0]   pnt_in [2][3];
   logic signed [DIFF_W-1:0]  diff [3];
   logic signed [DIFF_W-1:0]  rnd [3];
   logic signed [D_W-1:0]     d_ff [3];
   logic signed [D_W-1:0]     d_in [3];
   logic signed [2*D_W-1:0]   sq_full [3];
   logic [SQ_W-1:0]           sq_ff [3];
   logic [SQ_W-1:0]           sq_in [3];
   logic signed [ND_W-1:0]    nd_ff [3];
   logic signed [ND_W-1:0]    nd_in [3];
   logic [S_W-1:0]            s_ff, s_in;
   logic signed [NDU_W-1:0]   ndu_ff, ndu_in;

   // whole front moves unless the last stage cannot push
   assign en        = !(vld_ff[STG_N-1] && queue_full);
   assign req_stall = !en;
   assign push      = vld_ff[STG_N-1] && !queue_full;
   assign push_data = '{s: s_ff, ndu: ndu_ff};
   assign vld_in    = {vld_ff[STG_N-2:0], req_valid};
   assign bary_in   = req_payload;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   // weights w, u, v for source (0) and target (1), vertices a, b, c
   always_comb begin
      wgt[0][0] = 18'h10000 - {2'b00, bary_ff.source_bary_u} - {2'b00, bary_ff.source_bary_v};
      wgt[0][1] = {2'b00, bary_ff.source_bary_u};
      wgt[0][2] = {2'b00, bary_ff.source_bary_v};
      wgt[1][0] = 18'h10000 - {2'b00, bary_ff.target_bary_u} - {2'b00, bary_ff.target_bary_v};
      wgt[1][1] = {2'b00, bary_ff.target_bary_u};
      wgt[1][2] = {2'b00, bary_ff.target_bary_v};
      vert[0][0] = cfg.source_vertex_a;
      vert[0][1] = cfg.source_vertex_b;
      vert[0][2] = cfg.source_vertex_c;
      vert[1][0] = cfg.target_vertex_a;
      vert[1][1] = cfg.target_vertex_b;
      vert[1][2] = cfg.target_vertex_c;
   end

   // weight times coordinate products
   always_comb begin
      for (int p = 0; p < 2; p++) begin
         for (int a = 0; a < 3; a++) begin
            for (int t = 0; t < 3; t++) begin
               prod_in[p][a][t] = wgt[p][t] * coord_lane(vert[p][t], 2'(a));
            end
         end
      end
   end

   // mapped points in Q.28
   always_comb begin
      for (int p = 0; p < 2; p++) begin
         for (int a = 0; a < 3; a++) begin
            pnt_in[p][a] = PNT_W'(prod_ff[p][a][0]) + PNT_W'(prod_ff[p][a][1])
                         + PNT_W'(prod_ff[p][a][2]);
         end
      end
   end

   // difference, rounded half up to Q.16
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         if (cfg.adjoint_mode) begin
            diff[a] = DIFF_W'(pnt_ff[0][a]) - DIFF_W'(pnt_ff[1][a]);
         end else begin
            diff[a] = DIFF_W'(pnt_ff[1][a]) - DIFF_W'(pnt_ff[0][a]);
         end
         rnd[a]  = diff[a] + DIFF_W'(1 << (RND_SH - 1));
         d_in[a] = rnd[a][RND_SH+D_W-1:RND_SH];
      end
   end

   // squares and normal products
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         sq_full[a] = d_ff[a] * d_ff[a];
         sq_in[a]   = sq_full[a][SQ_W-1:0];
         nd_in[a]   = coord_lane(cfg.surface_normal, 2'(a)) * d_ff[a];
      end
   end

   // sums
   always_comb begin
      s_in   = S_W'(sq_ff[0]) + S_W'(sq_ff[1]) + S_W'(sq_ff[2]);
      ndu_in = NDU_W'(nd_ff[0]) + NDU_W'(nd_ff[1]) + NDU_W'(nd_ff[2]);
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (en) begin
         bary_ff <= bary_in;
         prod_ff <= prod_in;
         pnt_ff  <= pnt_in;
         d_ff    <= d_in;
         sq_ff   <= sq_in;
         nd_ff   <= nd_in;
         s_ff    <= s_in;
         ndu_ff  <= ndu_in;
      end
   end

endmodule

FILE: src/ldlk_fifo.sv
// Short queue between the front and the back of the pair kernel.
// Depends on ldlk_pkg.
`timescale 1ns / 1ps

module ldlk_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  ldlk_pkg::geom_type push_data,
   output logic               full,
   input  logic               pop,
   output logic               pop_valid,
   output ldlk_pkg::geom_type pop_data
);
   import ldlk_pkg::*;

   geom_type         mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   assign full      = (cnt_ff == CNT_W'(QUEUE_DEPTH));
   assign pop_valid = (cnt_ff != '0);
   assign pop_data  = mem_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: src/ldlk_back.sv
// Back of the pair kernel: square root, products and long division that
// turn |d|^2 and n.d into the saturated Q15.16 kernel value.
// Depends on ldlk_pkg.
`timescale 1ns / 1ps

module ldlk_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      pop_valid,
   input  ldlk_pkg::geom_type        pop_data,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output ldlk_pkg::rsp_payload_type rsp_payload
);
   import ldlk_pkg::*;

   localparam int NLO_W   = LO_W + INV4PI_W;
   localparam int NHI_W   = MAG_W - LO_W + INV4PI_W;
   localparam int DLO_W   = LO_W + Q_W;
   localparam int DHI_W   = S_W - LO_W + Q_W;
   localparam int M1_IDX  = Q_W + 1;
   localparam int M2_IDX  = M1_IDX + 1;
   localparam int DV_IDX  = M2_IDX + 1;
   localparam int OUT_IDX = DV_IDX + QUO_W + 1;
   localparam int STG_N   = OUT_IDX + 1;

   typedef struct packed {
      logic             neg;
      logic             zero;
      logic [S_W-1:0]   s;
      logic [NLO_W-1:0] nlo;
      logic [NHI_W-1:0] nhi;
      logic [NUM_W-1:0] num;
      logic [Q_W-1:0]   q;
      logic [X_W-1:0]   rem;
   } root_type;

   typedef struct packed {
      logic             neg;
      logic             zero;
      logic [NUM_W-1:0] num;
      logic [DLO_W-1:0] dlo;
      logic [DHI_W-1:0] dhi;
   } mul_type;

   typedef struct packed {
      logic             neg;
      logic             zero;
      logic [NUM_W-1:0] num;
      logic [DEN_W-1:0] den;
   } den_type;

   typedef struct packed {
      logic             neg;
      logic             zero;
      logic             big;
      logic [DEN_W-1:0] den;
      logic [NUM_W-1:0] rem;
      logic [QUO_W-1:0] quo;
   } div_type;

   logic             en;
   logic [STG_N-1:0] vld_ff, vld_in;

   root_type         root_ff [Q_W+1];
   root_type         root_in [Q_W+1];
   logic [X_W-1:0]   trial [Q_W+1];
   mul_type          mul_ff, mul_in;
   den_type          den_ff, den_in;
   div_type          div_ff [QUO_W+1];
   div_type          div_in [QUO_W+1];
   logic [NUM_W-1:0] rem_sh [QUO_W+1];
   logic [NUM_W-1:0] rem_dif [QUO_W+1];
   logic [NUM_W-1:0] rem_lo_mask [QUO_W+1];
   rsp_payload_type  out_ff, out_in;

   logic signed [NDU_W-1:0] mag_full;
   logic [MAG_W-1:0]        mag;
   logic [QUO_W-1:0]        limit;
   logic                    over;

   // pipeline advances whenever the output register is free or taken
   assign en          = !vld_ff[OUT_IDX] || !rsp_stall;
   assign pop         = pop_valid && en;
   assign vld_in      = {vld_ff[STG_N-2:0], pop_valid};
   assign rsp_valid   = vld_ff[OUT_IDX];
   assign rsp_payload = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   // entry: magnitude of n.d, split products with 1/(4 pi), root operand;
   // then integer square root, one result bit per stage
   always_comb begin
      mag_full        = pop_data.ndu[NDU_W-1] ? -pop_data.ndu : pop_data.ndu;
      mag             = mag_full[MAG_W-1:0];
      root_in[0].neg  = pop_data.ndu[NDU_W-1];
      root_in[0].zero = (pop_data.s == '0);
      root_in[0].s    = pop_data.s;
      root_in[0].nlo  = NLO_W'(mag[LO_W-1:0]) * NLO_W'(INV_4PI_Q32);
      root_in[0].nhi  = NHI_W'(mag[MAG_W-1:LO_W]) * NHI_W'(INV_4PI_Q32);
      root_in[0].num  = '0;
      root_in[0].q    = '0;
      root_in[0].rem  = X_W'({pop_data.s, 16'h0000});
      trial[0]        = '0;
      for (int k = 1; k <= Q_W; k++) begin
         root_in[k] = root_ff[k-1];
         trial[k]   = (X_W'(root_ff[k-1].q) << (Q_W - k + 1))
                    | (X_W'(1) << (2 * (Q_W - k)));
         if (root_ff[k-1].rem >= trial[k]) begin
            root_in[k].rem = root_ff[k-1].rem - trial[k];
            root_in[k].q   = root_ff[k-1].q | (Q_W'(1) << (Q_W - k));
         end
         if (k == 1) begin
            root_in[k].num = (NUM_W'(root_ff[k-1].nlo)
                           + (NUM_W'(root_ff[k-1].nhi) << LO_W)) << NUM_SH;
         end
      end
   end

   // denominator s * q, split in two partial products
   always_comb begin
      mul_in.neg  = root_ff[Q_W].neg;
      mul_in.zero = root_ff[Q_W].zero;
      mul_in.num  = root_ff[Q_W].num;
      mul_in.dlo  = DLO_W'(root_ff[Q_W].s[LO_W-1:0]) * DLO_W'(root_ff[Q_W].q);
      mul_in.dhi  = DHI_W'(root_ff[Q_W].s[S_W-1:LO_W]) * DHI_W'(root_ff[Q_W].q);
      den_in.neg  = mul_ff.neg;
      den_in.zero = mul_ff.zero;
      den_in.num  = mul_ff.num;
      den_in.den  = DEN_W'(mul_ff.dlo) + (DEN_W'(mul_ff.dhi) << LO_W);
   end

   // range check, then restoring division one quotient bit per stage
   always_comb begin
      div_in[0].neg  = den_ff.neg;
      div_in[0].zero = den_ff.zero;
      div_in[0].big  = (den_ff.num >> QUO_W) >= NUM_W'(den_ff.den);
      div_in[0].den  = den_ff.den;
      div_in[0].rem  = den_ff.num;
      div_in[0].quo  = '0;
      rem_sh[0]      = '0;
      rem_dif[0]     = '0;
      rem_lo_mask[0] = '0;
      for (int j = 1; j <= QUO_W; j++) begin
         div_in[j]      = div_ff[j-1];
         rem_sh[j]      = div_ff[j-1].rem >> (QUO_W - j);
         rem_dif[j]     = rem_sh[j] - NUM_W'(div_ff[j-1].den);
         rem_lo_mask[j] = (NUM_W'(1) << (QUO_W - j)) - NUM_W'(1);
         if (rem_sh[j] >= NUM_W'(div_ff[j-1].den)) begin
            div_in[j].rem = (rem_dif[j] << (QUO_W - j))
                          | (div_ff[j-1].rem & rem_lo_mask[j]);
            div_in[j].quo = div_ff[j-1].quo | (QUO_W'(1) << (QUO_W - j));
         end
      end
   end

   // sign, saturation and zero-distance result
   always_comb begin
      limit = div_ff[QUO_W].neg ? QUO_W'(33'h0_8000_0000) : QUO_W'(33'h0_7FFF_FFFF);
      over  = div_ff[QUO_W].big || (div_ff[QUO_W].quo > limit);
      if (div_ff[QUO_W].zero) begin
         out_in.kernel_value  = 32'sh7FFF_FFFF;
         out_in.saturated     = 1'b1;
         out_in.zero_distance = 1'b1;
      end else if (over) begin
         out_in.kernel_value  = div_ff[QUO_W].neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
         out_in.saturated     = 1'b1;
         out_in.zero_distance = 1'b0;
      end else begin
         out_in.kernel_value  = div_ff[QUO_W].neg ? -div_ff[QUO_W].quo[KV_W-1:0]
                                                  : div_ff[QUO_W].quo[KV_W-1:0];
         out_in.saturated     = 1'b0;
         out_in.zero_distance = 1'b0;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (en) begin
         root_ff <= root_in;
         mul_ff  <= mul_in;
         den_ff  <= den_in;
         div_ff  <= div_in;
         out_ff  <= out_in;
      end
   end

endmodule
